FILE: rtl/piecewise_linear_interpolator_assert.svh
// Assertion macros for the piecewise linear interpolator.
// Used by the top level only; expects clock and reset in scope.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication.
`define PLI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; imported by the controller, datapath and top level.
package pli_pkg;

   localparam int FRAC_BITS = 16;
   localparam int X_W       = FRAC_BITS + 1;
   localparam int Y_W       = 32;
   localparam int PH_W      = 6;
   localparam int QUO_W     = Y_W;
   localparam int MAG_W     = QUO_W + X_W;
   localparam int SUM_W     = QUO_W + 2;
   localparam int DCW       = $clog2(QUO_W);

   localparam logic [X_W-1:0] ONE_X = X_W'(1 << FRAC_BITS);

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_EVAL  = 2'd2;

   typedef struct packed {
      logic [1:0]            action;
      logic [X_W-1:0]        point_x;
      logic signed [Y_W-1:0] point_y;
      logic [X_W-1:0]        query_x;
   } req_type;

   typedef struct packed {
      logic signed [Y_W-1:0] value;
      logic                  status;
      logic [PH_W-1:0]       points_held;
   } rsp_type;

   typedef struct packed {
      logic [X_W-1:0]        x;
      logic signed [Y_W-1:0] y;
   } entry_type;

   // Table memory operations
   typedef enum logic [2:0] {
      MOP_NONE,
      MOP_RD_TOP,     // read last entry, pointer to it
      MOP_SHIFT,      // move read entry up one, read the one below
      MOP_MOVE,       // move read entry up one
      MOP_INS_ABOVE,  // new point just above pointer
      MOP_INS_AT,     // new point at pointer
      MOP_RD_FIRST,   // read entry 0
      MOP_RD_NEXT     // read entry above pointer
   } mem_op_type;

   // Operand set-up for the multiply/divide
   typedef enum logic [2:0] {
      OPS_NONE,
      OPS_BELOW,
      OPS_ABOVE,
      OPS_SEG,
      OPS_FLAT
   } ops_type;

   typedef struct packed {
      logic       capture;
      logic       cnt_clear;
      logic       cnt_inc;
      mem_op_type mop;
      ops_type    ops;
      logic       prev_load;
      logic       mul;
      logic       div_step;
      logic       fix;
   } cmd_type;

   typedef struct packed {
      logic cnt_full;
      logic cnt_empty;
      logic eval_zero;
      logic ptr_zero;
      logic ptr_last;
      logic move_up;
      logic reach;
      logic below;
      logic above;
      logic div_last;
   } sts_type;

endpackage

FILE: rtl/pli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pli_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pli_ctrl.sv
// Controller state machine for the piecewise linear interpolator.
// Depends on pli_pkg; drives the datapath through cmd_type, reads sts_type.
module pli_ctrl import pli_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_action,
   input  sts_type    sts,
   output logic       busy,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_LD_SHIFT = 9'b000000010,
      S_LD_PUT   = 9'b000000100,
      S_EV_FIRST = 9'b000001000,
      S_EV_SCAN  = 9'b000010000,
      S_EV_MUL   = 9'b000100000,
      S_EV_DIV   = 9'b001000000,
      S_EV_FIX   = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_action)
                  ACT_CLEAR: begin
                     cmd.cnt_clear = 1'b1;
                     state_in      = S_DONE;
                  end
                  ACT_LOAD: begin
                     if (sts.cnt_full) begin
                        state_in = S_DONE;
                     end else if (sts.cnt_empty) begin
                        state_in = S_LD_PUT;
                     end else begin
                        cmd.mop  = MOP_RD_TOP;
                        state_in = S_LD_SHIFT;
                     end
                  end
                  ACT_EVAL: begin
                     if (sts.eval_zero) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.mop  = MOP_RD_FIRST;
                        state_in = S_EV_FIRST;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_LD_SHIFT: begin
            if (sts.move_up) begin
               if (sts.ptr_zero) begin
                  cmd.mop  = MOP_MOVE;
                  state_in = S_LD_PUT;
               end else begin
                  cmd.mop = MOP_SHIFT;
               end
            end else begin
               cmd.mop     = MOP_INS_ABOVE;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_LD_PUT: begin
            cmd.mop     = MOP_INS_AT;
            cmd.cnt_inc = 1'b1;
            state_in    = S_DONE;
         end
         S_EV_FIRST: begin
            if (sts.below) begin
               cmd.ops  = OPS_BELOW;
               state_in = S_EV_MUL;
            end else if (sts.ptr_last) begin
               cmd.ops  = sts.above ? OPS_ABOVE : OPS_FLAT;
               state_in = S_EV_MUL;
            end else begin
               cmd.prev_load = 1'b1;
               cmd.mop       = MOP_RD_NEXT;
               state_in      = S_EV_SCAN;
            end
         end
         S_EV_SCAN: begin
            if (sts.reach) begin
               cmd.ops  = OPS_SEG;
               state_in = S_EV_MUL;
            end else if (sts.ptr_last) begin
               cmd.ops  = OPS_ABOVE;
               state_in = S_EV_MUL;
            end else begin
               cmd.prev_load = 1'b1;
               cmd.mop       = MOP_RD_NEXT;
            end
         end
         S_EV_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_EV_DIV;
         end
         S_EV_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_EV_FIX;
            end
         end
         S_EV_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

FILE: rtl/pli_dp.sv
// Datapath: breakpoint table, insertion and search pointers, multiply,
// restoring divider and saturation. Depends on pli_pkg and pli_ram.
module pli_dp import pli_pkg::*; #(
   parameter int MAX_POINTS = 32,
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   localparam int CW = $clog2(MAX_POINTS + 1)
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_item,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_item
);

   localparam int EW = $bits(entry_type);

   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   req_type               req_ff;
   entry_type             prev_ff;
   logic [QUO_W-1:0]      a_mag_ff;
   logic                  neg_ff;
   logic [X_W-1:0]        b_ff, d_ff;
   logic signed [Y_W-1:0] base_ff;
   logic [X_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [DCW-1:0]        div_cnt_ff;
   logic signed [Y_W-1:0] value_ff, value_sat;
   logic                  status_ff;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr, ptr_top;
   entry_type             wr_data, rd_entry, new_entry;
   logic [EW-1:0]         rd_raw;

   // operand set-up
   logic [Y_W:0]          op_a, op_mag;
   logic                  op_neg;
   logic [X_W-1:0]        op_b, op_d;
   logic signed [Y_W-1:0] op_base;

   logic [MAG_W-1:0]      prod;
   logic [X_W:0]          shifted;
   logic                  ge;
   logic [SUM_W-1:0]      mag_ext, q_ext, base_ext, sum;

   pli_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry  = entry_type'(rd_raw);
   assign new_entry = '{x: req_ff.point_x, y: req_ff.point_y};
   assign ptr_top   = AW'(count_ff - CW'(1));

   // table access
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = new_entry;
      rd_en   = 1'b0;
      rd_addr = ptr_ff;
      ptr_in  = cmd.capture ? '0 : ptr_ff;
      case (cmd.mop)
         MOP_RD_TOP: begin
            rd_en   = 1'b1;
            rd_addr = ptr_top;
            ptr_in  = ptr_top;
         end
         MOP_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + AW'(1);
            wr_data = rd_entry;
            rd_en   = 1'b1;
            rd_addr = ptr_ff - AW'(1);
            ptr_in  = ptr_ff - AW'(1);
         end
         MOP_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + AW'(1);
            wr_data = rd_entry;
         end
         MOP_INS_ABOVE: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + AW'(1);
         end
         MOP_INS_AT: begin
            wr_en = 1'b1;
         end
         MOP_RD_FIRST: begin
            rd_en   = 1'b1;
            rd_addr = '0;
            ptr_in  = '0;
         end
         MOP_RD_NEXT: begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff + AW'(1);
            ptr_in  = ptr_ff + AW'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clear) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end
   end

   // status back to the controller
   always_comb begin
      sts.cnt_full  = (count_ff == CW'(MAX_POINTS));
      sts.cnt_empty = (count_ff == '0);
      sts.eval_zero = (req_item.query_x == '0) || (req_item.query_x > ONE_X) ||
                      (count_ff == '0);
      sts.ptr_zero  = (ptr_ff == '0);
      sts.ptr_last  = ((CW'(ptr_ff) + CW'(1)) == count_ff);
      sts.move_up   = (rd_entry.x > req_ff.point_x);
      sts.reach     = (rd_entry.x >= req_ff.query_x);
      sts.below     = (req_ff.query_x < rd_entry.x);
      sts.above     = (req_ff.query_x > rd_entry.x);
      sts.div_last  = (div_cnt_ff == DCW'(QUO_W - 1));
   end

   // numerator factor, multiplier, divisor and offset for each case
   always_comb begin
      op_a    = {rd_entry.y[Y_W-1], rd_entry.y};
      op_b    = req_ff.query_x;
      op_d    = rd_entry.x;
      op_base = '0;
      case (cmd.ops)
         OPS_ABOVE: begin
            op_b = ONE_X - req_ff.query_x;
            op_d = ONE_X - rd_entry.x;
         end
         OPS_SEG: begin
            op_a    = {rd_entry.y[Y_W-1], rd_entry.y} - {prev_ff.y[Y_W-1], prev_ff.y};
            op_b    = req_ff.query_x - prev_ff.x;
            op_d    = rd_entry.x - prev_ff.x;
            op_base = prev_ff.y;
         end
         OPS_FLAT: begin
            op_a    = '0;
            op_b    = '0;
            op_d    = X_W'(1);
            op_base = rd_entry.y;
         end
         default: begin
         end
      endcase
      // zero-width segment: numerator is zero, keep the divider sane
      if (op_d == '0) begin
         op_d = X_W'(1);
      end
      op_neg = op_a[Y_W];
      op_mag = op_neg ? (~op_a + (Y_W+1)'(1)) : op_a;
   end

   // multiply, then one quotient bit per cycle
   assign prod    = MAG_W'(a_mag_ff) * MAG_W'(b_ff);
   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign ge      = (shifted >= {1'b0, d_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.mul) begin
         rem_in = prod[MAG_W-1:QUO_W];
         quo_in = prod[QUO_W-1:0];
      end else if (cmd.div_step) begin
         rem_in = ge ? X_W'(shifted - {1'b0, d_ff}) : X_W'(shifted);
         quo_in = {quo_ff[QUO_W-2:0], ge};
      end
   end

   // apply sign, add offset, saturate
   always_comb begin
      mag_ext  = SUM_W'(quo_ff);
      q_ext    = neg_ff ? (~mag_ext + SUM_W'(1)) : mag_ext;
      base_ext = {{(SUM_W-Y_W){base_ff[Y_W-1]}}, base_ff};
      sum      = q_ext + base_ext;
      if ((&sum[SUM_W-1:Y_W-1]) || !(|sum[SUM_W-1:Y_W-1])) begin
         value_sat = sum[Y_W-1:0];
      end else if (sum[SUM_W-1]) begin
         value_sat = {1'b1, {(Y_W-1){1'b0}}};
      end else begin
         value_sat = {1'b0, {(Y_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         div_cnt_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.mul) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + DCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.capture) begin
         req_ff    <= req_item;
         value_ff  <= '0;
         status_ff <= (req_item.action == ACT_LOAD) && sts.cnt_full;
      end else if (cmd.fix) begin
         value_ff <= value_sat;
      end
      if (cmd.prev_load) begin
         prev_ff <= rd_entry;
      end
      if (cmd.ops != OPS_NONE) begin
         a_mag_ff <= op_mag[QUO_W-1:0];
         neg_ff   <= op_neg;
         b_ff     <= op_b;
         d_ff     <= op_d;
         base_ff  <= op_base;
      end
   end

   assign rsp_item.value       = value_ff;
   assign rsp_item.status      = status_ff;
   assign rsp_item.points_held = PH_W'(count_ff);

endmodule

FILE: rtl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator, top level: controller plus datapath.
// Depends on pli_pkg, pli_ctrl, pli_dp (with pli_ram) and the assertion header.
//
// Each request beat (start high while busy is low) carries one action:
// clear, load a breakpoint, or evaluate at query_x. Exactly one response
// beat follows, shown on rsp_item for a single cycle with rsp_valid high;
// the receiver cannot hold it off, so it must take it in that cycle.
// Breakpoints live in a MAX_POINTS-deep RAM kept sorted by x; a new point
// goes after any equal keys, and a load into a full table is dropped with
// status set. x is unsigned Q1.16, y and the result signed Q16.16; the
// result is truncated toward zero and saturated to 32 bits.
// Clear, a dropped load, an unused action code and a trivial evaluate
// (x zero, x above one, empty table) go from idle straight to the
// response state. A load walks the table down from the top, one entry
// per cycle through the RAM's single read and write ports, moving each
// entry above the new point up by one. An evaluate scans up from entry
// 0 one entry per cycle until the segment is found, then runs the
// multiply, the restoring divider and the sign and saturation step in
// turn. busy stays high until the response cycle ends. The table needs
// no clearing after reset: only entries below the fill count are ever
// read.
module piecewise_linear_interpolator import pli_pkg::*; #(
   parameter int MAX_POINTS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   cmd_type cmd;
   sts_type sts;

   // sequencing: accept, table walk, multiply, divide, respond
   pli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_item.action),
      .sts        (sts),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   // table, pointers and arithmetic; response fields come straight
   // from its registers
   pli_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

   // shorthand terms for the checks below
   logic accept_beat;
   logic clear_beat;
   logic empty_rsp;
   logic drop_rsp;

   assign accept_beat = start && !busy;
   assign clear_beat  = accept_beat && (req_item.action == ACT_CLEAR);
   assign empty_rsp   = rsp_valid && (rsp_item.points_held == '0);
   assign drop_rsp    = rsp_valid && rsp_item.status;

`include "piecewise_linear_interpolator_assert.svh"

   // an accepted beat keeps the block busy until its response
   `PLI_ASSERT_NEXT(a_accept_busy, accept_beat, busy, "accepted beat did not raise busy")

   // the response strobe lasts one cycle per beat
   `PLI_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "response strobe held too long")

   // a dropped load reports no value
   `PLI_ASSERT_NOW(a_drop_zero, drop_rsp, rsp_item.value == '0, "dropped load with value")

   // clear answers on the next cycle with an empty table
   `PLI_ASSERT_NEXT(a_clear_resp, clear_beat, empty_rsp, "clear response wrong")

endmodule

FILE: verif/tb.sv
// Self-checking bench for piecewise_linear_interpolator: directed, then random beats.
// Depends on pli_pkg and the RTL; a shadow copy of the breakpoint table predicts each response.

module tb import pli_pkg::*;;

   localparam int          TABLE_DEPTH = 32;
   localparam int          ITEM_TARGET = 1250;
   localparam logic [1:0]  ACT_SPARE   = 2'd3;   // unused code, block just sends a response
   localparam logic        STATUS_FULL = 1'b1;
   localparam longint      ONE_Q       = longint'(ONE_X);
   localparam int          DRAIN_WAIT  = 90;     // longer than the worst evaluate

   // Shadow of the breakpoint table. Predicts the response of every accepted
   // request beat and matches it against the response beats in order.
   class pwl_shadow;
      logic [X_W-1:0] bx[TABLE_DEPTH];
      longint         by[TABLE_DEPTH];
      int             held;
      rsp_type        expected_rsps[$];
      int             errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      function longint clamp_q16(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint interpolate_at(logic [X_W-1:0] qx);
         longint x, x0, xl, xa, xb, ya, yb;
         int     i;
         x = longint'(qx);
         if (x == 0 || x > ONE_Q || held == 0) return 0;
         x0 = longint'(bx[0]);
         xl = longint'(bx[held-1]);
         if (x < x0) return clamp_q16(by[0] * x / x0);
         if (x > xl) return clamp_q16(by[held-1] * (ONE_Q - x) / (ONE_Q - xl));
         for (i = 1; i < held; i++) begin
            if (longint'(bx[i]) >= x) break;
         end
         // lone point hit exactly
         if (i >= held) return clamp_q16(by[0]);
         xa = longint'(bx[i-1]);
         xb = longint'(bx[i]);
         ya = by[i-1];
         yb = by[i];
         if (xb == xa) return clamp_q16(ya);
         return clamp_q16(ya + ((yb - ya) * (x - xa)) / (xb - xa));
      endfunction

      function void take_request(req_type r);
         rsp_type e;
         int      pos;
         e = '0;
         case (r.action)
            ACT_CLEAR: held = 0;
            ACT_LOAD: begin
               if (held >= TABLE_DEPTH) begin
                  e.status = STATUS_FULL;
               end else begin
                  // new point goes after any equal keys
                  pos = 0;
                  while (pos < held && bx[pos] <= r.point_x) pos++;
                  for (int k = held; k > pos; k--) begin
                     bx[k] = bx[k-1];
                     by[k] = by[k-1];
                  end
                  bx[pos] = r.point_x;
                  by[pos] = longint'($signed(r.point_y));
                  held++;
               end
            end
            ACT_EVAL: e.value = Y_W'(interpolate_at(r.query_x));
            default: ;
         endcase
         e.points_held = PH_W'(held);
         expected_rsps = {expected_rsps, e};
      endfunction

      function void match_response(rsp_type got);
         rsp_type e;
         if (expected_rsps.size() == 0) begin
            $error("response beat with nothing outstanding: value %0d status %0d held %0d",
                   $signed(got.value), got.status, got.points_held);
            errors++;
            return;
         end
         e = expected_rsps.pop_front();
         if (got.value !== e.value) begin
            $error("value: expected %0d, got %0d", $signed(e.value), $signed(got.value));
            errors++;
         end
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            errors++;
         end
         if (got.points_held !== e.points_held) begin
            $error("points_held: expected %0d, got %0d", e.points_held, got.points_held);
            errors++;
         end
      endfunction
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   pwl_shadow      table_shadow = new();
   logic [X_W-1:0] loaded_x[$];   // x values the stimulus believes are held
   int             beats_sent;
   int             burst_left;

   piecewise_linear_interpolator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Monitor: both sides sampled at the edge, before the block's own updates.
   // Response checked first so an expectation noted at the same edge cannot
   // be consumed by an earlier beat's response.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) table_shadow.match_response(rsp_item);
         if (start && !busy) table_shadow.take_request(req_item);
      end
   end

   // Random filler keeps the unused fields of each beat toggling.
   function automatic req_type make_beat(logic [1:0] act, logic [X_W-1:0] px,
                                         logic [Y_W-1:0] py, logic [X_W-1:0] qx);
      req_type r;
      r.action  = act;
      r.point_x = px;
      r.point_y = py;
      r.query_x = qx;
      return r;
   endfunction

   function automatic logic [X_W-1:0] any_x();
      return X_W'($urandom);
   endfunction

   function automatic logic [X_W-1:0] pick_point_x();
      case ($urandom_range(9))
         0: return '0;
         1: return ONE_X;
         2: return any_x();   // may lie beyond one
         3: return (loaded_x.size() != 0) ? loaded_x[$urandom_range(loaded_x.size()-1)]
                                          : ONE_X;
         4: return X_W'($urandom_range(16, 1));
         default: return X_W'($urandom_range(ONE_Q));
      endcase
   endfunction

   function automatic logic [Y_W-1:0] pick_point_y();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return Y_W'($urandom_range(200000)) - 32'd100000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [X_W-1:0] pick_query_x();
      logic [X_W-1:0] hx;
      case ($urandom_range(9))
         0: return '0;
         1: return ONE_X;
         2: return ONE_X + X_W'($urandom_range(2, 1));
         3: return any_x();
         4, 5, 6: begin
            if (loaded_x.size() == 0) return X_W'($urandom_range(ONE_Q));
            hx = loaded_x[$urandom_range(loaded_x.size()-1)];
            case ($urandom_range(2))
               0: return hx;
               1: return hx + 1'b1;
               default: return hx - 1'b1;
            endcase
         end
         default: return X_W'($urandom_range(ONE_Q));
      endcase
   endfunction

   // Drives one request beat and returns at the edge that accepts it. The
   // sender runs in bursts; at the end of a burst start drops for a random
   // gap so that beats arrive at every phase of the block's work.
   task automatic send_beat(input req_type item);
      int gap;
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (item.action != ACT_SPARE) beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start    <= 1'b0;
         req_item <= make_beat(2'($urandom), any_x(), $urandom, any_x());
         gap = ($urandom_range(3) == 0) ? $urandom_range(80, 1) : $urandom_range(3, 1);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(5);
      end
   endtask

   // Keeps the stimulus' own view of the table in step, then drives the beat.
   task automatic issue(input req_type item);
      case (item.action)
         ACT_CLEAR: loaded_x.delete();
         ACT_LOAD:  if (loaded_x.size() < TABLE_DEPTH) loaded_x = {loaded_x, item.point_x};
         default: ;
      endcase
      send_beat(item);
   endtask

   task automatic issue_load(input logic [X_W-1:0] px, input logic [Y_W-1:0] py);
      issue(make_beat(ACT_LOAD, px, py, any_x()));
   endtask

   task automatic issue_eval(input logic [X_W-1:0] qx);
      issue(make_beat(ACT_EVAL, any_x(), $urandom, qx));
   endtask

   task automatic issue_other(input logic [1:0] act);
      issue(make_beat(act, any_x(), $urandom, any_x()));
   endtask

   // Clear, fill with random points (sometimes past full), then query.
   task automatic table_sequence();
      int n_loads, n_evals;
      issue_other(ACT_CLEAR);
      n_loads = ($urandom_range(4) == 0) ? $urandom_range(36, 28) : $urandom_range(8, 1);
      n_evals = $urandom_range(12, 1);
      repeat (n_loads) issue_load(pick_point_x(), pick_point_y());
      repeat (n_evals) issue_eval(pick_query_x());
   endtask

   // Loads and evaluates mixed without a fresh clear, with the odd clear.
   task automatic broken_sequence();
      repeat ($urandom_range(6, 1)) begin
         case ($urandom_range(5))
            0:       issue_other(ACT_CLEAR);
            1, 2:    issue_load(pick_point_x(), pick_point_y());
            default: issue_eval(pick_query_x());
         endcase
      end
   endtask

   task automatic noise_beats();
      repeat ($urandom_range(4, 1)) issue(make_beat(2'($urandom), any_x(), $urandom, any_x()));
   endtask

   initial begin
      beats_sent = 0;
      burst_left = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, lone point, out-of-range queries, equal keys,
      // extreme y, points at zero, at one and past one, unused action code.
      issue_eval(17'h0_8000);
      issue_other(ACT_CLEAR);
      issue_load(17'h0_8000, 32'h0001_0000);
      issue_eval(17'h0_8000);                 // lone point, exact hit
      issue_eval(17'h0_0000);
      issue_eval(17'h1_0001);
      issue_eval(17'h0_4000);                 // below first point
      issue_eval(17'h0_C000);                 // above last point
      issue_load(17'h0_8000, 32'hFFFE_0000);  // equal key, zero-width segment
      issue_eval(17'h0_8000);
      issue_load(ONE_X, 32'h7FFF_FFFF);
      issue_load(17'h0_0000, 32'h8000_0000);
      issue_load(17'h1_FFFF, 32'h1234_5678);  // stored beyond one
      issue_eval(ONE_X);
      issue_eval(17'h0_C000);
      issue_eval(17'h0_0001);
      issue_eval(17'h0_7FFF);
      issue_other(ACT_SPARE);
      issue_eval(17'h1_FFFF);
      issue_other(ACT_CLEAR);
      issue_eval(17'h0_0001);

      // Random: mostly well-formed table sequences, some broken ones and noise.
      while (beats_sent < ITEM_TARGET) begin
         case ($urandom_range(19))
            0, 1, 2: broken_sequence();
            3, 4:    noise_beats();
            default: table_sequence();
         endcase
      end
      start <= 1'b0;

      // Let outstanding responses drain, then watch for strays.
      while (table_shadow.expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (table_shadow.errors == 0 && table_shadow.expected_rsps.size() == 0) begin
         $display("piecewise_linear_interpolator verification clean");
      end else begin
         $display("piecewise_linear_interpolator verification failed");
      end
      $finish;
   end

   // Watchdog: ends the run as failed if it has not finished.
   initial begin
      #2_000_000;
      $display("piecewise_linear_interpolator verification failed");
      $finish;
   end

endmodule

FILE: piecewise_linear_interpolator.f
+incdir+rtl
rtl/pli_pkg.sv
rtl/pli_ram.sv
rtl/pli_ctrl.sv
rtl/pli_dp.sv
rtl/piecewise_linear_interpolator.sv
verif/tb.sv
